// ----- rtl/ofpt_pkg.sv -----
// shared types, codes and constants of the open-file position table
`timescale 1ns / 1ps

package ofpt_pkg;

    localparam int unsigned MAX_FILES_DEF = 512;
    localparam int unsigned MAX_OPEN_DEF  = 64;

    // operation codes
    localparam logic [3:0] M_ADD   = 4'd0;
    localparam logic [3:0] M_OPEN  = 4'd1;
    localparam logic [3:0] M_CLOSE = 4'd2;
    localparam logic [3:0] M_READ  = 4'd3;
    localparam logic [3:0] M_SEEK  = 4'd4;
    localparam logic [3:0] M_GPOS  = 4'd5;
    localparam logic [3:0] M_GLEN  = 4'd6;
    localparam logic [3:0] M_INFO  = 4'd7;
    localparam logic [3:0] M_WRITE = 4'd8;

    // position modes
    localparam logic [1:0] P_AT_MARK   = 2'd0;
    localparam logic [1:0] P_FROM_START = 2'd1;
    localparam logic [1:0] P_FROM_END  = 2'd2;
    localparam logic [1:0] P_FROM_MARK = 2'd3;

    // status codes
    localparam logic [2:0] ST_OK           = 3'd0;
    localparam logic [2:0] ST_EOF          = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND    = 3'd2;
    localparam logic [2:0] ST_PARAM        = 3'd3;
    localparam logic [2:0] ST_BAD_REF      = 3'd4;
    localparam logic [2:0] ST_WRITE_DENIED = 3'd5;

    // allocation block rounding
    localparam logic [31:0] ALLOC_ROUND = 32'h0000_01FF;

    typedef struct packed {
        logic [8:0]  file;
        logic        fork_res;
        logic [31:0] pos;
    } t_slot_entry;

    typedef struct packed {
        logic [31:0] dlen;
        logic [31:0] rlen;
    } t_cat_entry;

    function automatic int unsigned f_aw(input int unsigned n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

endpackage

// ----- rtl/ofpt_store.sv -----
// catalogue and slot table memories with registered read ports
`timescale 1ns / 1ps

module ofpt_store #(
    parameter int unsigned MAX_FILES = ofpt_pkg::MAX_FILES_DEF,
    parameter int unsigned MAX_OPEN  = ofpt_pkg::MAX_OPEN_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_cat_we,
    input  logic [ofpt_pkg::f_aw(MAX_FILES)-1:0]      i_cat_waddr,
    input  ofpt_pkg::t_cat_entry                      i_cat_wdata,
    input  logic [ofpt_pkg::f_aw(MAX_FILES)-1:0]      i_cat_raddr,
    output ofpt_pkg::t_cat_entry                      o_cat_rdata,
    input  logic                                      i_slot_we,
    input  logic [ofpt_pkg::f_aw(MAX_OPEN)-1:0]       i_slot_waddr,
    input  ofpt_pkg::t_slot_entry                     i_slot_wdata,
    input  logic [ofpt_pkg::f_aw(MAX_OPEN)-1:0]       i_slot_raddr,
    output ofpt_pkg::t_slot_entry                     o_slot_rdata
);
    import ofpt_pkg::*;

    t_cat_entry  cat_mem  [MAX_FILES];
    t_slot_entry slot_mem [MAX_OPEN];
    t_cat_entry  r_cat_rdata;
    t_slot_entry r_slot_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cat_we) begin
            cat_mem[i_cat_waddr] <= i_cat_wdata;
        end
        r_cat_rdata <= cat_mem[i_cat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_slot_we) begin
            slot_mem[i_slot_waddr] <= i_slot_wdata;
        end
        r_slot_rdata <= slot_mem[i_slot_raddr];
    end

    assign o_cat_rdata  = r_cat_rdata;
    assign o_slot_rdata = r_slot_rdata;

endmodule

// ----- rtl/open_file_position_table_top.sv -----
// open-file position table: catalogue, slot table and operation sequencer
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------------------
//  command  | start in, busy out        | i_mode .. i_resource_length
//  result   | o_result_valid strobe     | o_status .. o_allocated_length
//
//  add file and errors found at decode end in the decode state; slot operations pass
//  through slot read, slot latch, catalogue read, position and finish. open scans the
//  slot flags one per cycle, then goes on at catalogue read; block info by index scans
//  them, then goes on at slot read. each word is shown for one cycle; the receiver
//  cannot stall. busy is high from acceptance until the result strobe.
//  reset clears the file count and the slot flags; memories need no clearing.
`timescale 1ns / 1ps

module open_file_position_table_top #(
    parameter int unsigned MAX_FILES = ofpt_pkg::MAX_FILES_DEF,
    parameter int unsigned MAX_OPEN  = ofpt_pkg::MAX_OPEN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [3:0]  i_mode,
    input  logic [15:0] i_ref_number,
    input  logic [8:0]  i_file_index,
    input  logic        i_fork_select,
    input  logic [1:0]  i_position_mode,
    input  logic signed [31:0] i_seek_offset,
    input  logic [31:0] i_request_count,
    input  logic [6:0]  i_nth_open,
    input  logic [31:0] i_data_length,
    input  logic [31:0] i_resource_length,
    output logic        o_result_valid,
    output logic [2:0]  o_status,
    output logic [6:0]  o_out_ref_number,
    output logic [8:0]  o_out_file_index,
    output logic        o_is_resource,
    output logic [31:0] o_position,
    output logic [31:0] o_actual_count,
    output logic [31:0] o_fork_length,
    output logic [31:0] o_allocated_length
);
    import ofpt_pkg::*;

    localparam int unsigned AW   = f_aw(MAX_FILES);
    localparam int unsigned SW   = f_aw(MAX_OPEN);
    localparam int unsigned CNTW = $clog2(MAX_FILES + 1);
    localparam int unsigned NCW  = $clog2(MAX_OPEN + 1);
    localparam int unsigned NW   = (NCW > 7) ? NCW : 7;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_SRD  = 3'd3;
    localparam logic [2:0] S_SLT  = 3'd4;
    localparam logic [2:0] S_CRD  = 3'd5;
    localparam logic [2:0] S_POS  = 3'd6;
    localparam logic [2:0] S_FIN  = 3'd7;

    logic [2:0]          r_state;
    logic [MAX_OPEN-1:0] r_used;
    logic [CNTW-1:0]     r_file_count;
    logic                r_valid;

    logic [3:0]  r_mode;
    logic [15:0] r_rn;
    logic [8:0]  r_fidx;
    logic        r_fork_sel;
    logic [1:0]  r_pmode;
    logic [31:0] r_off;
    logic [31:0] r_req;
    logic [6:0]  r_nth;
    logic [31:0] r_dlen;
    logic [31:0] r_rlen;

    logic [SW-1:0]  r_slot;
    logic [SW-1:0]  r_scan;
    logic [NCW-1:0] r_cnt;
    logic [8:0]     r_file;
    logic           r_fork;
    logic [31:0]    r_pos;
    logic [31:0]    r_len;
    logic [31:0]    r_newpos;
    logic [2:0]     r_seek_st;

    t_cat_entry  cat_rdata;
    t_slot_entry slot_rdata;
    t_cat_entry  cat_wdata;
    t_slot_entry slot_wdata;
    logic        cat_we;
    logic        slot_we;
    logic [AW-1:0] cat_waddr;
    logic [AW-1:0] cat_raddr;
    logic [AW+8:0] fidx_ext;
    logic [CNTW+8:0] cnt_ext;

    // decode
    logic [15:0]   rn_m1;
    logic [SW-1:0] ref_idx;
    logic          ref_ok;
    logic          cat_full;
    logic          fidx_known;
    logic          d_err;
    logic [2:0]    d_code;
    logic [2:0]    d_next;

    // position and count
    logic [31:0] len_sel;
    logic [31:0] rd_pos;
    logic [33:0] sk_base;
    logic [33:0] sk_add;
    logic [33:0] sk_sum;
    logic [31:0] avail;
    logic [31:0] grant;
    logic [31:0] fin_pos;
    logic [31:0] fin_cnt;
    logic [2:0]  fin_st;
    logic [NW-1:0] cnt_next_ext;
    logic [NW-1:0] nth_ext;
    logic [NCW-1:0] cnt_inc;
    logic [SW+8:0] ref_out;

    assign busy = (r_state != S_IDLE);

    ofpt_store #(
        .MAX_FILES (MAX_FILES),
        .MAX_OPEN  (MAX_OPEN)
    ) u_store (
        .i_clk        (i_clk),
        .i_cat_we     (cat_we),
        .i_cat_waddr  (cat_waddr),
        .i_cat_wdata  (cat_wdata),
        .i_cat_raddr  (cat_raddr),
        .o_cat_rdata  (cat_rdata),
        .i_slot_we    (slot_we),
        .i_slot_waddr (r_slot),
        .i_slot_wdata (slot_wdata),
        .i_slot_raddr (r_slot),
        .o_slot_rdata (slot_rdata)
    );

    assign rn_m1      = r_rn - 16'd1;
    assign ref_idx    = rn_m1[SW-1:0];
    assign ref_ok     = (r_rn != 16'd0) && (r_rn <= 16'(MAX_OPEN)) && r_used[ref_idx];
    assign cat_full   = (r_file_count == CNTW'(MAX_FILES));
    assign cnt_ext    = {9'd0, r_file_count};
    assign fidx_known = ({{CNTW{1'b0}}, r_fidx} < cnt_ext);

    always_comb begin
        d_err  = 1'b1;
        d_code = ST_PARAM;
        d_next = S_IDLE;
        case (r_mode)
            M_ADD: begin
                d_err = cat_full;
            end
            M_OPEN: begin
                if (!fidx_known) begin
                    d_code = ST_NOT_FOUND;
                end else begin
                    d_err  = 1'b0;
                    d_next = S_SCAN;
                end
            end
            M_CLOSE, M_READ, M_SEEK, M_GPOS, M_GLEN: begin
                if (!ref_ok) begin
                    d_code = ST_BAD_REF;
                end else begin
                    d_err  = 1'b0;
                    d_next = S_SRD;
                end
            end
            M_INFO: begin
                if (r_nth != 7'd0) begin
                    d_err  = 1'b0;
                    d_next = S_SCAN;
                end else if (!ref_ok) begin
                    d_code = ST_BAD_REF;
                end else begin
                    d_err  = 1'b0;
                    d_next = S_SRD;
                end
            end
            M_WRITE: begin
                d_code = ST_WRITE_DENIED;
            end
            default: begin
                d_code = ST_PARAM;
            end
        endcase
    end

    // catalogue addressing; an opened index is always below the file count
    assign fidx_ext  = {{AW{1'b0}}, r_file};
    assign cat_raddr = fidx_ext[AW-1:0];
    assign cat_waddr = r_file_count[AW-1:0];
    assign cat_we    = (r_state == S_DEC) && (r_mode == M_ADD) && !cat_full;
    assign cat_wdata = '{dlen: r_dlen, rlen: r_rlen};

    assign len_sel = r_fork ? cat_rdata.rlen : cat_rdata.dlen;

    always_comb begin
        case (r_pmode)
            P_FROM_START: rd_pos = r_off[31] ? 32'd0 : r_off;
            P_FROM_END:   rd_pos = len_sel + r_off;
            P_FROM_MARK:  rd_pos = r_pos + r_off;
            default:      rd_pos = r_pos;
        endcase
        case (r_pmode)
            P_FROM_START: sk_base = 34'd0;
            P_FROM_END:   sk_base = {2'b00, len_sel};
            default:      sk_base = {2'b00, r_pos};
        endcase
        sk_add = (r_pmode == P_AT_MARK) ? 34'd0 : {{2{r_off[31]}}, r_off};
        sk_sum = sk_base + sk_add;
    end

    assign avail = r_len - r_newpos;
    assign grant = (r_req < avail) ? r_req : avail;

    always_comb begin
        fin_pos = r_newpos;
        fin_cnt = 32'd0;
        fin_st  = ST_OK;
        case (r_mode)
            M_READ: begin
                fin_pos = r_newpos + grant;
                fin_cnt = grant;
                fin_st  = (grant < r_req) ? ST_EOF : ST_OK;
            end
            M_SEEK: begin
                fin_st = r_seek_st;
            end
            default: begin
                fin_st = ST_OK;
            end
        endcase
    end

    assign slot_we    = (r_state == S_FIN) &&
                        ((r_mode == M_OPEN) || (r_mode == M_READ) || (r_mode == M_SEEK));
    assign slot_wdata = '{file: r_file, fork_res: r_fork, pos: fin_pos};

    assign cnt_inc      = r_cnt + NCW'(1);
    assign cnt_next_ext = NW'(cnt_inc);
    assign nth_ext      = NW'(r_nth);
    assign ref_out      = {9'd0, r_slot} + (SW + 9)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_used       <= '0;
            r_file_count <= '0;
            r_valid      <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_mode     <= i_mode;
                        r_rn       <= i_ref_number;
                        r_fidx     <= i_file_index;
                        r_fork_sel <= i_fork_select;
                        r_pmode    <= i_position_mode;
                        r_off      <= i_seek_offset;
                        r_req      <= i_request_count;
                        r_nth      <= i_nth_open;
                        r_dlen     <= i_data_length;
                        r_rlen     <= i_resource_length;
                        r_state    <= S_DEC;
                    end
                end
                S_DEC: begin
                    r_slot <= ref_idx;
                    r_scan <= '0;
                    r_cnt  <= '0;
                    if (d_err || (r_mode == M_ADD)) begin
                        r_valid            <= 1'b1;
                        o_status           <= d_err ? d_code : ST_OK;
                        o_out_ref_number   <= 7'd0;
                        o_out_file_index   <= d_err ? 9'd0 : cnt_ext[8:0];
                        o_is_resource      <= 1'b0;
                        o_position         <= 32'd0;
                        o_actual_count     <= 32'd0;
                        o_fork_length      <= 32'd0;
                        o_allocated_length <= 32'd0;
                        if (!d_err) begin
                            r_file_count <= r_file_count + CNTW'(1);
                        end
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= d_next;
                    end
                end
                S_SCAN: begin
                    r_scan <= r_scan + SW'(1);
                    if (r_mode == M_OPEN && !r_used[r_scan]) begin
                        r_slot  <= r_scan;
                        r_file  <= r_fidx;
                        r_fork  <= r_fork_sel;
                        r_pos   <= 32'd0;
                        r_state <= S_CRD;
                    end else if (r_mode == M_INFO && r_used[r_scan] &&
                                 cnt_next_ext == nth_ext) begin
                        r_slot  <= r_scan;
                        r_state <= S_SRD;
                    end else if (r_scan == SW'(MAX_OPEN - 1)) begin
                        // ran off the end of the slot table
                        r_valid            <= 1'b1;
                        o_status           <= (r_mode == M_OPEN) ? ST_PARAM : ST_BAD_REF;
                        o_out_ref_number   <= 7'd0;
                        o_out_file_index   <= 9'd0;
                        o_is_resource      <= 1'b0;
                        o_position         <= 32'd0;
                        o_actual_count     <= 32'd0;
                        o_fork_length      <= 32'd0;
                        o_allocated_length <= 32'd0;
                        r_state            <= S_IDLE;
                    end
                    if (r_used[r_scan]) begin
                        r_cnt <= cnt_inc;
                    end
                end
                S_SRD: begin
                    r_state <= S_SLT;
                end
                S_SLT: begin
                    r_file  <= slot_rdata.file;
                    r_fork  <= slot_rdata.fork_res;
                    r_pos   <= slot_rdata.pos;
                    r_state <= S_CRD;
                end
                S_CRD: begin
                    r_state <= S_POS;
                end
                S_POS: begin
                    r_len     <= len_sel;
                    r_seek_st <= ST_OK;
                    if (r_mode == M_READ) begin
                        r_newpos <= (rd_pos > len_sel) ? len_sel : rd_pos;
                    end else if (r_mode == M_SEEK) begin
                        if (sk_sum[33]) begin
                            r_newpos  <= 32'd0;
                            r_seek_st <= ST_PARAM;
                        end else if (sk_sum > {2'b00, len_sel}) begin
                            r_newpos  <= len_sel;
                            r_seek_st <= ST_EOF;
                        end else begin
                            r_newpos <= sk_sum[31:0];
                        end
                    end else begin
                        r_newpos <= r_pos;
                    end
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_valid            <= 1'b1;
                    o_status           <= fin_st;
                    o_out_ref_number   <= ref_out[6:0];
                    o_out_file_index   <= r_file;
                    o_is_resource      <= r_fork;
                    o_position         <= fin_pos;
                    o_actual_count     <= fin_cnt;
                    o_fork_length      <= r_len;
                    o_allocated_length <= (r_len + ALLOC_ROUND) & ~ALLOC_ROUND;
                    if (r_mode == M_OPEN) begin
                        r_used[r_slot] <= 1'b1;
                    end else if (r_mode == M_CLOSE) begin
                        r_used[r_slot] <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result_valid = r_valid;

`ifndef NO_ASSERTIONS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for more than one cycle");

    a_fin_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_result_valid && !busy))
        else $error("slot operation finished without a result");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_file_count <= CNTW'(MAX_FILES))
        else $error("file count beyond catalogue size");
`endif

endmodule
